// ===== src/swmm_pkg.sv =====
package swmm_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 9;
    localparam int WLEN_W      = 9;

    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MODE          = 1'd1;

    localparam logic MODE_MIN = 1'b0;
    localparam logic MODE_MAX = 1'b1;

    // Commands broadcast to every cell; at most one is active per cycle
    typedef struct packed {
        logic age_inc;   // new request taken: every live entry ages by one
        logic shift;     // front expired: each cell takes its upper neighbor
        logic pop;       // back cell drops itself if the new sample dominates it
        logic push;      // first free cell loads the new sample
    } cmd_t;

    // Status gathered from the chain
    typedef struct packed {
        logic front_valid;
        logic back_dom;
    } stat_t;

endpackage

// ===== src/swmm_cell.sv =====
module swmm_cell #(
    parameter int SAMPLE_WIDTH = 32,
    parameter int AGE_W        = 9
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  swmm_pkg::cmd_t                 cmd,
    input  logic                           mode,
    input  logic signed [SAMPLE_WIDTH-1:0] x,
    input  logic                           prv_valid,
    input  logic                           nxt_valid,
    input  logic signed [SAMPLE_WIDTH-1:0] nxt_value,
    input  logic        [AGE_W-1:0]        nxt_age,
    output logic                           valid,
    output logic signed [SAMPLE_WIDTH-1:0] value,
    output logic        [AGE_W-1:0]        age,
    output logic                           back_dom
);

    logic                           valid_reg;
    logic                           valid_next;
    logic signed [SAMPLE_WIDTH-1:0] value_reg;
    logic signed [SAMPLE_WIDTH-1:0] value_next;
    logic        [AGE_W-1:0]        age_reg;
    logic        [AGE_W-1:0]        age_next;
    logic                           dom;
    logic                           is_back;

    // ties go to the new sample
    assign dom     = (mode == swmm_pkg::MODE_MIN) ? (value_reg >= x) : (value_reg <= x);
    assign is_back = valid_reg && !nxt_valid;

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        age_next   = age_reg;
        if (cmd.age_inc && valid_reg)
        begin
            age_next = age_reg + AGE_W'(1);
        end
        if (cmd.shift)
        begin
            valid_next = nxt_valid;
            value_next = nxt_value;
            age_next   = nxt_age;
        end
        if (cmd.pop && is_back && dom)
        begin
            valid_next = 1'b0;
        end
        if (cmd.push && !valid_reg && prv_valid)
        begin
            valid_next = 1'b1;
            value_next = x;
            age_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        age_reg   <= age_next;
    end

    assign valid    = valid_reg;
    assign value    = value_reg;
    assign age      = age_reg;
    assign back_dom = is_back && dom;

endmodule

// ===== src/swmm_ctrl.sv =====
module swmm_ctrl #(
    parameter int SAMPLE_WIDTH = 32,
    parameter int MAX_WINDOW   = 256,
    parameter int CNT_W        = 9
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]      sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]      extreme_value,
    output logic                                window_full,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [swmm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [swmm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  swmm_pkg::stat_t                     stat,
    input  logic signed [SAMPLE_WIDTH-1:0]      front_value,
    input  logic        [CNT_W-1:0]             front_age,
    output swmm_pkg::cmd_t                      cmd,
    output logic                                mode,
    output logic signed [SAMPLE_WIDTH-1:0]      x
);

    localparam int CMP_W = (CNT_W > swmm_pkg::WLEN_W) ? CNT_W : swmm_pkg::WLEN_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EXPIRE = 2'd1;
    localparam logic [1:0] ST_POP    = 2'd2;
    localparam logic [1:0] ST_PUSH   = 2'd3;

    logic [1:0]                     state_reg;
    logic [1:0]                     state_next;
    logic [swmm_pkg::WLEN_W-1:0]    wlen_reg;
    logic                           mode_reg;
    logic [CNT_W-1:0]               seen_reg;
    logic [CNT_W-1:0]               seen_next;
    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] out_value_reg;
    logic                           out_full_reg;
    logic [CMP_W-1:0]               wl_ext;
    logic [CNT_W-1:0]               w_eff;
    logic                           accept;
    logic                           out_free;
    logic                           expired;

    assign wl_ext = CMP_W'(wlen_reg);

    always_comb
    begin
        if (wl_ext == '0)
        begin
            w_eff = CNT_W'(1);
        end
        else if (wl_ext > CMP_W'(MAX_WINDOW))
        begin
            w_eff = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            w_eff = CNT_W'(wl_ext);
        end
    end

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign expired  = stat.front_valid && (front_age >= w_eff);

    always_comb
    begin
        cmd.age_inc = accept;
        cmd.shift   = (state_reg == ST_EXPIRE) && expired;
        cmd.pop     = (state_reg == ST_POP) && stat.back_dom;
        cmd.push    = (state_reg == ST_PUSH) && out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXPIRE;
                end
            end
            ST_EXPIRE:
            begin
                if (!expired)
                begin
                    state_next = ST_POP;
                end
            end
            ST_POP:
            begin
                if (!stat.back_dom)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        seen_next = seen_reg;
        if (accept && (seen_reg < CNT_W'(MAX_WINDOW)))
        begin
            seen_next = seen_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.push)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
            wlen_reg      <= swmm_pkg::WLEN_W'(9);
            mode_reg      <= swmm_pkg::MODE_MIN;
        end
        else
        begin
            state_reg     <= state_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    swmm_pkg::REG_WINDOW_LENGTH:
                    begin
                        wlen_reg <= cfg_data[swmm_pkg::WLEN_W-1:0];
                    end
                    swmm_pkg::REG_MODE:
                    begin
                        mode_reg <= cfg_data[0];
                    end
                    default:
                    begin
                        mode_reg <= mode_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg <= sample;
        end
        if (cmd.push)
        begin
            // empty deque: the new sample becomes the front
            out_value_reg <= stat.front_valid ? front_value : x_reg;
            out_full_reg  <= (seen_reg >= w_eff);
        end
    end

    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign extreme_value = out_value_reg;
    assign window_full   = out_full_reg;
    assign cfg_ready     = 1'b1;
    assign mode          = mode_reg;
    assign x             = x_reg;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_EXPIRE))
        else $error("accepted request did not start expiry");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.age_inc, cmd.shift, cmd.pop, cmd.push}))
        else $error("more than one chain command");

    a_seen_sat: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= CNT_W'(MAX_WINDOW))
        else $error("sample count passed window limit");

    a_weff_range: assert property (@(posedge clk) disable iff (!rst_n)
        (w_eff != '0) && (w_eff <= CNT_W'(MAX_WINDOW)))
        else $error("effective window out of range");

    a_push_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |=> out_valid_reg && (state_reg == ST_IDLE))
        else $error("push did not produce a result");
`endif

endmodule

// ===== src/sliding_window_min_max.sv =====
// Rolling minimum (mode 0) or maximum (mode 1) over the last window_length samples,
// kept as a monotonic deque in a chain of MAX_WINDOW cells: cell 0 holds the front
// (oldest candidate, which is the answer), the back is the highest live cell. Each
// request goes from acceptance through the expire, pop and push states: candidates
// that have aged out expire from the front (one chain shift per cycle), dominated
// candidates are dropped from the back (one per cycle), and the push waits while the
// previous result is still held by out_stall. in_stall stays high until the result is
// written and the next request is taken in the cycle after, so no new sample enters
// before the last one is done. window_full is low until window_length samples have
// been seen since reset; extreme_value is still driven then. window_length 0 acts as 1,
// values above MAX_WINDOW act as MAX_WINDOW. Write configuration only while the block
// is idle.
module sliding_window_min_max #(
    parameter int MAX_WINDOW   = 256,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]      sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]      extreme_value,
    output logic                                window_full,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [swmm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [swmm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);

    swmm_pkg::cmd_t                 cmd;
    swmm_pkg::stat_t                stat;
    logic                           mode;
    logic signed [SAMPLE_WIDTH-1:0] x;
    logic [MAX_WINDOW-1:0]          valid_vec;
    logic [MAX_WINDOW-1:0]          back_dom_vec;
    logic signed [SAMPLE_WIDTH-1:0] value_arr [MAX_WINDOW];
    logic        [CNT_W-1:0]        age_arr   [MAX_WINDOW];

    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        logic                           prv_valid;
        logic                           nxt_valid;
        logic signed [SAMPLE_WIDTH-1:0] nxt_value;
        logic        [CNT_W-1:0]        nxt_age;

        if (i == 0)
        begin : g_first
            assign prv_valid = 1'b1;
        end
        else
        begin : g_mid
            assign prv_valid = valid_vec[i-1];
        end

        if (i == MAX_WINDOW - 1)
        begin : g_last
            assign nxt_valid = 1'b0;
            assign nxt_value = '0;
            assign nxt_age   = '0;
        end
        else
        begin : g_link
            assign nxt_valid = valid_vec[i+1];
            assign nxt_value = value_arr[i+1];
            assign nxt_age   = age_arr[i+1];
        end

        swmm_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .AGE_W        (CNT_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .mode      (mode),
            .x         (x),
            .prv_valid (prv_valid),
            .nxt_valid (nxt_valid),
            .nxt_value (nxt_value),
            .nxt_age   (nxt_age),
            .valid     (valid_vec[i]),
            .value     (value_arr[i]),
            .age       (age_arr[i]),
            .back_dom  (back_dom_vec[i])
        );
    end

    assign stat.front_valid = valid_vec[0];
    assign stat.back_dom    = |back_dom_vec;

    swmm_ctrl #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .MAX_WINDOW   (MAX_WINDOW),
        .CNT_W        (CNT_W)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample        (sample),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .extreme_value (extreme_value),
        .window_full   (window_full),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .stat          (stat),
        .front_value   (value_arr[0]),
        .front_age     (age_arr[0]),
        .cmd           (cmd),
        .mode          (mode),
        .x             (x)
    );

endmodule

// ===== bench/swmm_checker.sv =====
`timescale 1ns / 1ps

module swmm_checker #(
    parameter int MAX_WINDOW   = 256,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]      sample,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]      extreme_value,
    input  logic                                window_full,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [swmm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [swmm_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                  fail_count,
    output int                                  pending,
    output int                                  checked,
    output int                                  full_count,
    output int                                  max_depth
);

    localparam int POS_MOD     = 2 * MAX_WINDOW;
    localparam int WLEN_RESET  = 9;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic signed [SAMPLE_WIDTH-1:0] value;
        int                             position;
    } candidate_t;

    typedef struct {
        logic signed [SAMPLE_WIDTH-1:0] value;
        logic                           full;
    } window_result_t;

    candidate_t                         candidates[$];
    window_result_t                     expected_q[$];
    int                                 next_pos;
    int                                 seen_count;
    logic [swmm_pkg::WLEN_W-1:0]        wlen;
    logic                               mode;
    int                                 n_fail;
    int                                 n_checked;
    int                                 n_full;
    int                                 deepest;

    initial
    begin
        n_fail    = 0;
        n_checked = 0;
        n_full    = 0;
        deepest   = 0;
    end

    function automatic window_result_t step_window(input logic signed [SAMPLE_WIDTH-1:0] x);
        int                             w;
        int                             age;
        logic signed [SAMPLE_WIDTH-1:0] back;
        logic                           drop;
        candidate_t                     c;
        window_result_t                 r;
        w = int'(wlen);
        if (w < 1)
            w = 1;
        if (w > MAX_WINDOW)
            w = MAX_WINDOW;
        while (candidates.size() > 0)
        begin
            age = (next_pos + POS_MOD - candidates[0].position) % POS_MOD;
            if (age < w)
                break;
            candidates.delete(0);
        end
        while (candidates.size() > 0)
        begin
            back = candidates[$].value;
            drop = (mode == swmm_pkg::MODE_MAX) ? (back <= x) : (back >= x);
            if (!drop)
                break;
            candidates.delete(candidates.size() - 1);
        end
        if (candidates.size() < MAX_WINDOW)
        begin
            c.value    = x;
            c.position = next_pos;
            candidates.insert(candidates.size(), c);
        end
        if (candidates.size() > deepest)
            deepest = candidates.size();
        next_pos = (next_pos + 1) % POS_MOD;
        if (seen_count < MAX_WINDOW)
            seen_count++;
        r.value = candidates[0].value;
        r.full  = (seen_count >= w);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        window_result_t exp_r;
        if (!rst_n)
        begin
            candidates.delete();
            expected_q.delete();
            next_pos   = 0;
            seen_count = 0;
            wlen       = swmm_pkg::WLEN_W'(WLEN_RESET);
            mode       = swmm_pkg::MODE_MIN;
            pending    <= 0;
            fail_count <= n_fail;
            checked    <= 0;
            full_count <= 0;
            max_depth  <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    swmm_pkg::REG_WINDOW_LENGTH: wlen = cfg_data[swmm_pkg::WLEN_W-1:0];
                    swmm_pkg::REG_MODE:          mode = cfg_data[0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                expected_q.insert(expected_q.size(), step_window(sample));
            if (out_valid && !out_stall)
            begin
                n_checked++;
                if (window_full === 1'b1)
                    n_full++;
                if (expected_q.size() == 0)
                begin
                    if (n_fail < MAX_REPORTS)
                        $display("%0t: unexpected result extreme_value=%0d window_full=%0b",
                                 $realtime, extreme_value, window_full);
                    n_fail++;
                end
                else
                begin
                    exp_r = expected_q[0];
                    expected_q.delete(0);
                    if (exp_r.value !== extreme_value || exp_r.full !== window_full)
                    begin
                        if (n_fail < MAX_REPORTS)
                            $display("%0t: result %0d value exp %0d got %0d full exp %0b got %0b",
                                     $realtime, n_checked, exp_r.value, extreme_value,
                                     exp_r.full, window_full);
                        n_fail++;
                    end
                end
            end
            pending    <= expected_q.size();
            fail_count <= n_fail;
            checked    <= n_checked;
            full_count <= n_full;
            max_depth  <= deepest;
        end
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_WINDOW       = 256;
    localparam int SAMPLE_WIDTH     = 32;
    localparam int RANDOM_PER_PHASE = 270;
    localparam int STALL_LIMIT      = 5000;
    localparam int SETTLE_CYCLES    = 64;

    localparam logic signed [SAMPLE_WIDTH-1:0] S_MIN = 32'h8000_0000;
    localparam logic signed [SAMPLE_WIDTH-1:0] S_MAX = 32'h7FFF_FFFF;

    typedef enum int {
        PAT_NOISE,
        PAT_NARROW,
        PAT_RAMP_UP,
        PAT_RAMP_DOWN,
        PAT_EXTREMES
    } pattern_e;

    logic                                   clk       = 1'b0;
    logic                                   rst_n     = 1'b0;
    logic                                   in_valid  = 1'b0;
    logic                                   in_stall;
    logic signed [SAMPLE_WIDTH-1:0]         sample    = '0;
    logic                                   out_valid;
    logic                                   out_stall = 1'b0;
    logic signed [SAMPLE_WIDTH-1:0]         extreme_value;
    logic                                   window_full;
    logic                                   cfg_valid = 1'b0;
    logic                                   cfg_ready;
    logic [swmm_pkg::CFG_INDEX_W-1:0]       cfg_index = '0;
    logic [swmm_pkg::CFG_DATA_W-1:0]        cfg_data  = '0;

    int fail_count;
    int pending;
    int checked;
    int full_count;
    int max_depth;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int n_sent      = 0;
    int n_writes    = 0;
    int idle_cycles = 0;

    always #5 clk = ~clk;

    sliding_window_min_max #(
        .MAX_WINDOW   (MAX_WINDOW),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample        (sample),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .extreme_value (extreme_value),
        .window_full   (window_full),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    swmm_checker #(
        .MAX_WINDOW   (MAX_WINDOW),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample        (sample),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .extreme_value (extreme_value),
        .window_full   (window_full),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked       (checked),
        .full_count    (full_count),
        .max_depth     (max_depth)
    );

    always @(posedge clk)
        out_stall <= (rx_idle_pct > 0) && ($urandom_range(99) < rx_idle_pct);

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                         idle_cycles, pending);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic push_sample(input logic signed [SAMPLE_WIDTH-1:0] v);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        n_sent++;
    endtask

    // hold off new requests until every result is back
    task automatic quiesce();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic configure(input int wlen_value, input logic mode_value);
        logic [swmm_pkg::CFG_DATA_W-1:0] d;
        cfg_valid <= 1'b1;
        cfg_index <= swmm_pkg::REG_WINDOW_LENGTH;
        cfg_data  <= wlen_value[swmm_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        d         = swmm_pkg::CFG_DATA_W'($urandom);
        d[0]      = mode_value;
        cfg_index <= swmm_pkg::REG_MODE;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        n_writes  += 2;
    endtask

    function automatic int pick_window();
        case ($urandom_range(9))
            0:       return 0;
            1:       return 1;
            2:       return 2;
            3:       return MAX_WINDOW;
            4:       return $urandom_range(MAX_WINDOW + 1, 511);
            5, 6:    return $urandom_range(3, 16);
            7, 8:    return $urandom_range(17, MAX_WINDOW - 1);
            default: return $urandom_range(1, MAX_WINDOW);
        endcase
    endfunction

    function automatic pattern_e pick_pattern();
        int r;
        r = $urandom_range(99);
        if (r < 25)
            return PAT_NOISE;
        if (r < 45)
            return PAT_NARROW;
        if (r < 65)
            return PAT_RAMP_UP;
        if (r < 85)
            return PAT_RAMP_DOWN;
        return PAT_EXTREMES;
    endfunction

    task automatic run_segment(input int n_items, input pattern_e pat);
        logic signed [SAMPLE_WIDTH-1:0] v;
        v = $signed($urandom) >>> 1;
        for (int i = 0; i < n_items; i++)
        begin
            case (pat)
                PAT_NOISE:     v = $urandom;
                PAT_NARROW:    v = $signed($urandom_range(8)) - 4;
                PAT_RAMP_UP:   v = v + $urandom_range(0, 1000);
                PAT_RAMP_DOWN: v = v - $urandom_range(0, 1000);
                default:
                begin
                    case ($urandom_range(5))
                        0:       v = S_MIN;
                        1:       v = S_MAX;
                        2:       v = 0;
                        3:       v = -1;
                        4:       v = S_MIN + 1;
                        default: v = S_MAX - 1;
                    endcase
                end
            endcase
            push_sample(v);
        end
    endtask

    initial
    begin
        int   target;
        logic deep_mode;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: window 9, minimum; extremes, warm-up and ties
        push_sample(S_MAX);
        push_sample(S_MIN);
        push_sample(0);
        push_sample(-1);
        push_sample(1);
        push_sample(5);
        push_sample(5);
        push_sample(5);
        push_sample(S_MIN);
        push_sample(S_MAX);
        // zero length acts as one
        quiesce();
        configure(0, swmm_pkg::MODE_MAX);
        push_sample(3);
        push_sample(-3);
        push_sample(S_MAX);
        push_sample(S_MIN);
        // above the maximum, clamped
        quiesce();
        configure(300, swmm_pkg::MODE_MIN);
        push_sample(10);
        push_sample(20);
        push_sample(30);
        // shrink mid-stream
        quiesce();
        configure(2, swmm_pkg::MODE_MIN);
        push_sample(40);
        push_sample(40);
        push_sample(-7);
        quiesce();
        configure(511, swmm_pkg::MODE_MAX);
        push_sample(S_MIN);
        push_sample(S_MAX);
        push_sample(S_MAX);

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    tx_idle_pct = 32;
                    rx_idle_pct <= 81;
                end
                1:
                begin
                    tx_idle_pct = 81;
                    rx_idle_pct <= 32;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct <= 0;
                end
            endcase
            target = n_sent + RANDOM_PER_PHASE;
            if (ph == 0)
            begin
                // monotone run fills the whole candidate list
                deep_mode = 1'($urandom_range(1));
                quiesce();
                configure(MAX_WINDOW, deep_mode);
                run_segment(270, (deep_mode == swmm_pkg::MODE_MAX) ? PAT_RAMP_DOWN : PAT_RAMP_UP);
            end
            while (n_sent < target)
            begin
                quiesce();
                configure(pick_window(), 1'($urandom_range(1)));
                run_segment($urandom_range(20, 90), pick_pattern());
            end
        end

        quiesce();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d samples sent over %0d register writes, %0d results checked (%0d full)",
                 n_sent, n_writes, checked, full_count);
        $display("window lengths 0 to 511 in both modes, deepest candidate list %0d", max_depth);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
